// File: rtl/erc_pkg.sv
// erc_pkg: shared constants and types for the ellipse region classifier
// no dependencies
package erc_pkg;
  localparam int unsigned NumEntriesDefault = 6;
  localparam int unsigned CoordWidthDefault = 20;
  localparam int unsigned RotWidth          = 16;
  localparam int unsigned RegionWidth       = 3;
  localparam int unsigned IndexWidth        = 3;

  localparam logic ActLoad     = 1'b0;
  localparam logic ActClassify = 1'b1;

  // status from the serial tester to the sequencer
  typedef struct packed {
    logic done;
    logic hit;
  } test_status_t;
endpackage

// File: rtl/erc_serial_mul.sv
// erc_serial_mul: unsigned shift-and-add multiplier, one multiplier bit per cycle
// depends on nothing
module erc_serial_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [AW-1:0]      a_i,
  input  logic [BW-1:0]      b_i,
  output logic               done_o,
  output logic [AW+BW-1:0]   prod_o
);
  localparam int unsigned CW = $clog2(BW + 1);
  logic [AW+BW-1:0] acc_q, acc_d, mcand_q, mcand_d;
  logic [BW-1:0]    mplr_q, mplr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;

  always_comb begin
    acc_d = acc_q; mcand_d = mcand_q; mplr_d = mplr_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      acc_d   = '0;
      mcand_d = {{BW{1'b0}}, a_i};
      mplr_d  = b_i;
      cnt_d   = CW'(BW);
      busy_d  = 1'b1;
    end else if (busy_q) begin
      if (mplr_q[0]) acc_d = acc_q + mcand_q;
      mcand_d = mcand_q << 1;
      mplr_d  = mplr_q >> 1;
      cnt_d   = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; mcand_q <= mcand_d; mplr_q <= mplr_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
endmodule

// File: rtl/erc_tester.sv
// erc_tester: exact point-in-ellipse test for one entry, built on one serial multiplier
// depends on erc_pkg and erc_serial_mul
module erc_tester #(
  parameter int unsigned CoordWidth = erc_pkg::CoordWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [CoordWidth-1:0]  px_i,
  input  logic signed [CoordWidth-1:0]  py_i,
  input  logic signed [CoordWidth-1:0]  cx_i,
  input  logic signed [CoordWidth-1:0]  cy_i,
  input  logic        [CoordWidth-2:0]  w_i,
  input  logic        [CoordWidth-2:0]  h_i,
  input  logic signed [erc_pkg::RotWidth-1:0] cos_i,
  input  logic signed [erc_pkg::RotWidth-1:0] sin_i,
  output erc_pkg::test_status_t         status_o
);
  import erc_pkg::*;
  localparam int unsigned DW = CoordWidth + 1;         // dx, dy magnitude
  localparam int unsigned PW = DW + RotWidth;           // one product
  localparam int unsigned UW = PW + 1;                  // |u|, |t|
  localparam int unsigned AW = CoordWidth - 1;
  localparam int unsigned QW = 2 * UW;                  // u^2
  localparam int unsigned MW = 2 * UW + 2 * AW;         // u^2 h^2
  localparam int unsigned OW = MW + 3;                  // 4(...) and rhs with 2^30 slack
  localparam int unsigned RW = 4 * AW + 30;
  localparam int unsigned LW = (OW > RW) ? OW : RW;
  localparam int unsigned XW = (UW > 2 * AW) ? UW : 2 * AW; // multiplicand width
  localparam int unsigned YW = QW;                       // multiplier width

  // each multiply step multiplies two operands, taken from registers or from the entry inputs
  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001, S_CD   = 14'b00000000000010,
    S_SDY  = 14'b00000000000100, S_SDX  = 14'b00000000001000,
    S_CDY  = 14'b00000000010000, S_UU   = 14'b00000000100000,
    S_TT   = 14'b00000001000000, S_HH   = 14'b00000010000000,
    S_WW   = 14'b00000100000000, S_UH   = 14'b00001000000000,
    S_TW   = 14'b00010000000000, S_RR   = 14'b00100000000000,
    S_CMP  = 14'b01000000000000, S_DONE = 14'b10000000000000
  } tst_state_e;

  tst_state_e st_q, st_d;
  logic signed [DW-1:0] dx_q, dy_q;
  logic signed [UW-1:0] u_q, t_q;
  logic [QW-1:0] uu_q, tt_q;
  logic [2*AW-1:0] hh_q, ww_q;
  logic [LW-1:0] lhs_q, rhs_q;
  logic inside_q;
  logic mstart;
  logic [XW-1:0] ma;
  logic [YW-1:0] mb;
  logic mdone;
  logic [XW+YW-1:0] mp;
  logic neg_q;
  logic signed [PW:0] sp;

  erc_serial_mul #(.AW(XW), .BW(YW)) u_mul (
    .clk_i, .rst_ni, .start_i(mstart), .a_i(ma), .b_i(mb), .done_o(mdone), .prod_o(mp)
  );

  function automatic logic [DW-1:0] mag_d(input logic signed [DW-1:0] v);
    mag_d = v[DW-1] ? DW'(-v) : v;
  endfunction
  function automatic logic [RotWidth:0] mag_r(input logic signed [RotWidth-1:0] v);
    mag_r = v[RotWidth-1] ? (RotWidth+1)'(-{v[RotWidth-1], v}) : {1'b0, v};
  endfunction
  function automatic logic [UW-1:0] mag_u(input logic signed [UW-1:0] v);
    mag_u = v[UW-1] ? UW'(-v) : v;
  endfunction

  // operand selection per step
  always_comb begin
    ma = '0; mb = '0;
    unique case (st_q)
      S_CD:  begin ma = XW'(mag_d(dx_q)); mb = YW'(mag_r(cos_i)); end
      S_SDY: begin ma = XW'(mag_d(dy_q)); mb = YW'(mag_r(sin_i)); end
      S_SDX: begin ma = XW'(mag_d(dx_q)); mb = YW'(mag_r(sin_i)); end
      S_CDY: begin ma = XW'(mag_d(dy_q)); mb = YW'(mag_r(cos_i)); end
      S_UU:  begin ma = XW'(mag_u(u_q)); mb = YW'(mag_u(u_q)); end
      S_TT:  begin ma = XW'(mag_u(t_q)); mb = YW'(mag_u(t_q)); end
      S_HH:  begin ma = XW'(h_i); mb = YW'(h_i); end
      S_WW:  begin ma = XW'(w_i); mb = YW'(w_i); end
      S_UH:  begin ma = XW'(hh_q); mb = uu_q; end
      S_TW:  begin ma = XW'(ww_q); mb = tt_q; end
      S_RR:  begin ma = XW'(hh_q); mb = YW'(ww_q); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // signed product of the current step (sign from operand signs, flipped for the subtracted c*dy)
  always_comb begin
    logic [PW:0] pm;
    pm = (PW+1)'(mp);
    sp = neg_q ? -$signed(pm) : $signed(pm);
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (start_i) st_d = S_CD;
      S_CD, S_SDY, S_SDX, S_CDY, S_UU, S_TT, S_HH, S_WW, S_UH, S_TW, S_RR: ;
      S_CMP:  st_d = S_DONE;
      S_DONE: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
    if (mdone) begin
      unique case (st_q)
        S_CD:  st_d = S_SDY;
        S_SDY: st_d = S_SDX;
        S_SDX: st_d = S_CDY;
        S_CDY: st_d = S_UU;
        S_UU:  st_d = S_TT;
        S_TT:  st_d = S_HH;
        S_HH:  st_d = S_WW;
        S_WW:  st_d = S_UH;
        S_UH:  st_d = S_TW;
        S_TW:  st_d = S_RR;
        S_RR:  st_d = S_CMP;
        default: st_d = st_q;
      endcase
    end
  end

  // launch a multiply on entry into each multiply step
  logic go_q;
  assign mstart = go_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      go_q <= 1'b0;
    end else begin
      st_q <= st_d;
      go_q <= (st_d != st_q) && (st_d != S_CMP) && (st_d != S_DONE) && (st_d != S_IDLE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && start_i) begin
      dx_q <= {px_i[CoordWidth-1], px_i} - {cx_i[CoordWidth-1], cx_i};
      dy_q <= {py_i[CoordWidth-1], py_i} - {cy_i[CoordWidth-1], cy_i};
    end
    if (go_q) begin
      unique case (st_q)
        S_CD:  neg_q <= dx_q[DW-1] ^ cos_i[RotWidth-1];
        S_SDY: neg_q <= dy_q[DW-1] ^ sin_i[RotWidth-1];
        S_SDX: neg_q <= dx_q[DW-1] ^ sin_i[RotWidth-1];
        S_CDY: neg_q <= ~(dy_q[DW-1] ^ cos_i[RotWidth-1]);
        default: neg_q <= 1'b0;
      endcase
    end
    if (mdone) begin
      unique case (st_q)
        S_CD:  u_q <= UW'(sp);
        S_SDY: u_q <= u_q + UW'(sp);
        S_SDX: t_q <= UW'(sp);
        S_CDY: t_q <= t_q + UW'(sp);
        S_UU:  uu_q <= QW'(mp);
        S_TT:  tt_q <= QW'(mp);
        S_HH:  hh_q <= (2*AW)'(mp);
        S_WW:  ww_q <= (2*AW)'(mp);
        S_UH:  lhs_q <= LW'(mp);
        S_TW:  lhs_q <= (lhs_q + LW'(mp)) << 2;
        S_RR:  rhs_q <= LW'(mp) << 30;
        default: ;
      endcase
    end
    if (st_q == S_CMP) inside_q <= lhs_q < rhs_q;
  end

  assign status_o.done = (st_q == S_DONE);
  assign status_o.hit  = inside_q;

  a_done_from_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DONE) |-> $past(st_q == S_CMP)) else $error("done without compare");
  a_one_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_q |=> !go_q) else $error("double multiply launch");
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE) |-> !mdone) else $error("multiplier done while idle");
endmodule

// File: rtl/ellipse_region_classifier.sv
// ellipse_region_classifier: top level, entry table, scan sequencer and output register
// depends on erc_pkg and erc_tester
//
// usage
//   s_axis: one request per item. tuser = action (0 load, 1 classify),
//   tdata carries entry_index, point_x, point_y, center_x, center_y,
//   full_width, full_height, rot_cos, rot_sin packed from bit 0 up
//   load requests give no result and leave the block ready for the next request
//   classify requests scan valid entries in order, stopping at the first hit
//   m_axis: tdata = region (first containing entry, NUM_ENTRIES if none)
// scan
//   each tested entry runs eleven serial multiplies on one shared shift-add
//   multiplier, plus a launch and a compare; a skipped invalid entry runs no
//   multiply; the result goes to the output register once the scan ends
//   one request is in flight at a time; the next is taken the cycle after
//   the result has left the output register
// reset
//   clears all valid bits and control, so no entry matches until loaded
// stall
//   a result waits in the output register while m_axis_tready is low; a new
//   request is not taken until that result has left
module ellipse_region_classifier #(
  parameter int unsigned NUM_ENTRIES = erc_pkg::NumEntriesDefault,
  parameter int unsigned COORD_WIDTH = erc_pkg::CoordWidthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: entry_index, point_x, point_y, center_x, center_y, full_width,
  // full_height, rot_cos, rot_sin, zero fill to whole bytes
  input  logic [((erc_pkg::IndexWidth + 6*COORD_WIDTH - 2 + 2*erc_pkg::RotWidth + 7)/8)*8-1:0]
               s_axis_tdata,
  input  logic s_axis_tuser,   // tuser: action
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [7:0] m_axis_tdata  // tdata: region, zero fill
);
  import erc_pkg::*;
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned AW = CW - 1;
  localparam int unsigned EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  // field offsets in tdata
  localparam int unsigned OPx = IndexWidth;
  localparam int unsigned OPy = OPx + CW;
  localparam int unsigned OCx = OPy + CW;
  localparam int unsigned OCy = OCx + CW;
  localparam int unsigned OW_ = OCy + CW;
  localparam int unsigned OH  = OW_ + AW;
  localparam int unsigned OC  = OH + AW;
  localparam int unsigned OS  = OC + RotWidth;

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001, T_SCAN = 4'b0010, T_WAIT = 4'b0100, T_OUT = 4'b1000
  } top_state_e;

  top_state_e st_q, st_d;
  logic [NUM_ENTRIES-1:0] valid_q;
  logic signed [CW-1:0] tcx_q [NUM_ENTRIES];
  logic signed [CW-1:0] tcy_q [NUM_ENTRIES];
  logic [AW-1:0] tw_q [NUM_ENTRIES];
  logic [AW-1:0] th_q [NUM_ENTRIES];
  logic signed [RotWidth-1:0] tc_q [NUM_ENTRIES];
  logic signed [RotWidth-1:0] ts_q [NUM_ENTRIES];
  logic signed [CW-1:0] px_q, py_q;
  logic [EW:0] k_q, k_d;              // scan index, reaches NUM_ENTRIES
  logic [RegionWidth-1:0] region_q, region_d;
  logic tstart;
  test_status_t tst;
  logic in_acc, out_acc;
  logic [IndexWidth-1:0] widx;

  assign s_axis_tready = (st_q == T_IDLE);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign widx    = s_axis_tdata[IndexWidth-1:0];

  erc_tester #(.CoordWidth(CW)) u_tst (
    .clk_i, .rst_ni, .start_i(tstart),
    .px_i(px_q), .py_i(py_q),
    .cx_i(tcx_q[k_q[EW-1:0]]), .cy_i(tcy_q[k_q[EW-1:0]]),
    .w_i(tw_q[k_q[EW-1:0]]), .h_i(th_q[k_q[EW-1:0]]),
    .cos_i(tc_q[k_q[EW-1:0]]), .sin_i(ts_q[k_q[EW-1:0]]),
    .status_o(tst)
  );

  always_comb begin
    st_d = st_q; k_d = k_q; region_d = region_q; tstart = 1'b0;
    unique case (st_q)
      T_IDLE: if (in_acc && s_axis_tuser == ActClassify) begin
        k_d = '0;
        st_d = T_SCAN;
      end
      T_SCAN: begin
        // skip invalid entries, launch a test on a valid one, report no hit after the last
        if (k_q == (EW+1)'(NUM_ENTRIES)) begin
          region_d = RegionWidth'(NUM_ENTRIES);
          st_d = T_OUT;
        end else if (valid_q[k_q[EW-1:0]]) begin
          tstart = 1'b1;
          st_d = T_WAIT;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      T_WAIT: if (tst.done) begin
        if (tst.hit) begin
          region_d = RegionWidth'(k_q);
          st_d = T_OUT;
        end else begin
          k_d = k_q + 1'b1;
          st_d = T_SCAN;
        end
      end
      T_OUT: if (out_acc) st_d = T_IDLE;
      default: st_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= T_IDLE;
      valid_q <= '0;
      k_q     <= '0;
    end else begin
      st_q <= st_d;
      k_q  <= k_d;
      if (in_acc && s_axis_tuser == ActLoad && widx < IndexWidth'(NUM_ENTRIES))
        valid_q[widx[EW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    region_q <= region_d;
    if (in_acc && s_axis_tuser == ActClassify) begin
      px_q <= s_axis_tdata[OPx +: CW];
      py_q <= s_axis_tdata[OPy +: CW];
    end
    if (in_acc && s_axis_tuser == ActLoad && widx < IndexWidth'(NUM_ENTRIES)) begin
      tcx_q[widx[EW-1:0]] <= s_axis_tdata[OCx +: CW];
      tcy_q[widx[EW-1:0]] <= s_axis_tdata[OCy +: CW];
      tw_q[widx[EW-1:0]]  <= s_axis_tdata[OW_ +: AW];
      th_q[widx[EW-1:0]]  <= s_axis_tdata[OH +: AW];
      tc_q[widx[EW-1:0]]  <= s_axis_tdata[OC +: RotWidth];
      ts_q[widx[EW-1:0]]  <= s_axis_tdata[OS +: RotWidth];
    end
  end

  assign m_axis_tvalid = (st_q == T_OUT);
  assign m_axis_tdata  = {{(8-RegionWidth){1'b0}}, region_q};

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(region_q)))
    else $error("result dropped under stall");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != T_IDLE) |-> !s_axis_tready) else $error("request taken while busy");
  a_region_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (region_q <= RegionWidth'(NUM_ENTRIES))) else $error("bad region");
  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == T_WAIT) |-> valid_q[k_q[EW-1:0]]) else $error("testing invalid entry");
endmodule

// File: verif/testbench.sv
// testbench: self-checking bench for ellipse_region_classifier, with directed table and random load/classify traffic
// depends on erc_pkg and the rtl of ellipse_region_classifier
module testbench;
  import erc_pkg::*;

  localparam int unsigned NumEntries = 6;
  localparam int unsigned DataWidth  = 160;
  localparam longint      CycleLimit = 64'd40_000_000;

  typedef logic [127:0] wide_t;

  typedef struct {
    logic        action;
    logic [2:0]  idx;
    logic [19:0] px, py, cx, cy;
    logic [18:0] w, h;
    logic [15:0] c, s;
    int          region;  // typed-in region, -1 means use the predictor
  } request_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DataWidth-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;

  always #5 clk_i = ~clk_i;

  ellipse_region_classifier dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // shadow copy of the ellipse table
  logic               tbl_valid [NumEntries];
  logic signed [19:0] tbl_cx [NumEntries];
  logic signed [19:0] tbl_cy [NumEntries];
  logic        [18:0] tbl_w [NumEntries];
  logic        [18:0] tbl_h [NumEntries];
  logic signed [15:0] tbl_c [NumEntries];
  logic signed [15:0] tbl_s [NumEntries];

  logic [7:0] region_q [$];
  int  errors = 0;
  int  tx_idle = 0, rx_idle = 0;
  bit  hold_req = 1'b0, hold_done = 1'b0;
  longint cycles = 0;

  // exact strict containment, wide unsigned products
  function automatic bit ellipse_contains(int k, logic signed [19:0] px,
                                          logic signed [19:0] py);
    longint dx, dy, u, t;
    wide_t um, tm, w, h, lhs, rhs;
    dx = longint'(px) - longint'(tbl_cx[k]);
    dy = longint'(py) - longint'(tbl_cy[k]);
    u  = longint'(tbl_c[k]) * dx + longint'(tbl_s[k]) * dy;
    t  = longint'(tbl_s[k]) * dx - longint'(tbl_c[k]) * dy;
    um = wide_t'(u < 0 ? -u : u);
    tm = wide_t'(t < 0 ? -t : t);
    w  = wide_t'(tbl_w[k]);
    h  = wide_t'(tbl_h[k]);
    lhs = (um * um * h * h + tm * tm * w * w) << 2;
    rhs = (w * w * h * h) << 30;
    return lhs < rhs;
  endfunction

  // applies one accepted request, returns the region for a classify
  function automatic int apply_request(request_t r);
    if (r.action == ActLoad) begin
      if (r.idx < NumEntries) begin
        tbl_valid[r.idx] = 1'b1;
        tbl_cx[r.idx] = r.cx;  tbl_cy[r.idx] = r.cy;
        tbl_w[r.idx]  = r.w;   tbl_h[r.idx]  = r.h;
        tbl_c[r.idx]  = r.c;   tbl_s[r.idx]  = r.s;
      end
      return -1;
    end
    for (int k = 0; k < NumEntries; k++)
      if (tbl_valid[k] && ellipse_contains(k, r.px, r.py)) return k;
    return NumEntries;
  endfunction

  task automatic send(request_t r);
    int reg_out;
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.action;
    s_axis_tdata  <= {7'b0, r.s, r.c, r.h, r.w, r.cy, r.cx, r.py, r.px, r.idx};
    do @(posedge clk_i); while (!s_axis_tready);
    reg_out = apply_request(r);
    if (r.action == ActClassify)
      region_q.push_back(8'(r.region >= 0 ? r.region : reg_out));
  endtask

  function automatic request_t mk_load(int idx, int cx, int cy, int w, int h,
                                       int c, int s);
    request_t r;
    r = '{action: ActLoad, idx: 3'(idx), px: 20'($urandom), py: 20'($urandom),
          cx: 20'(cx), cy: 20'(cy), w: 19'(w), h: 19'(h), c: 16'(c), s: 16'(s),
          region: -1};
    return r;
  endfunction

  function automatic request_t mk_point(int px, int py, int region);
    request_t r;
    r = '{action: ActClassify, idx: 3'($urandom), px: 20'(px), py: 20'(py),
          cx: 20'($urandom), cy: 20'($urandom), w: 19'($urandom), h: 19'($urandom),
          c: 16'($urandom), s: 16'($urandom), region: region};
    return r;
  endfunction

  function automatic request_t random_request();
    int k, w, h, c, s;
    real a;
    if ($urandom_range(99) < 35) begin
      // load: mostly legal index, a few ignored ones
      k = ($urandom_range(19) == 0) ? $urandom_range(7, 6) : $urandom_range(5);
      case ($urandom_range(9))
        0: begin w = $urandom_range(524287); h = $urandom_range(524287); end
        1: begin w = 0; h = $urandom_range(1, 4000); end
        2: begin w = 524287; h = 524287; end
        default: begin w = $urandom_range(1, 60000); h = $urandom_range(1, 60000); end
      endcase
      if ($urandom_range(3) == 0) begin
        c = int'($urandom); s = int'($urandom);
      end else begin
        a = $urandom_range(3599) * 3.14159265358979 / 1800.0;
        c = $rtoi(32767.0 * $cos(a));
        s = $rtoi(32767.0 * $sin(a));
      end
      return mk_load(k, int'($urandom), int'($urandom), w, h, c, s);
    end
    k = $urandom_range(NumEntries - 1);
    if ($urandom_range(99) < 70 && tbl_valid[k]) begin
      // aim near a loaded ellipse so both inside and outside occur
      w = int'(tbl_w[k] > tbl_h[k] ? tbl_w[k] : tbl_h[k]);
      return mk_point(int'(tbl_cx[k]) + $urandom_range(w) - w / 2,
                      int'(tbl_cy[k]) + $urandom_range(w) - w / 2, -1);
    end
    return mk_point(int'($urandom), int'($urandom), -1);
  endfunction

  // receiver side: random ready, one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 4000;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (region_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, m_axis_tdata);
        errors++;
      end else begin
        if (m_axis_tdata !== region_q[0]) begin
          $display("%0t: region mismatch, expected %0d, actual %0d", $time,
                   region_q[0], m_axis_tdata);
          errors++;
        end
        void'(region_q.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    request_t dir_q [$];
    for (int k = 0; k < NumEntries; k++) tbl_valid[k] = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, ignored indexes, extremes, zero axes, raw rotation
    dir_q.push_back(mk_point(0, 0, NumEntries));
    dir_q.push_back(mk_point(-524288, 524287, NumEntries));
    dir_q.push_back(mk_load(6, 0, 0, 524287, 524287, 32767, 0));
    dir_q.push_back(mk_load(7, 0, 0, 524287, 524287, 32767, 0));
    dir_q.push_back(mk_point(0, 0, NumEntries));
    dir_q.push_back(mk_load(0, 0, 0, 524287, 524287, 32767, 0));
    dir_q.push_back(mk_point(0, 0, 0));
    dir_q.push_back(mk_point(-524288, -524288, -1));
    dir_q.push_back(mk_point(524287, 524287, -1));
    dir_q.push_back(mk_load(5, -524288, -524288, 0, 524287, -32768, -32768));
    dir_q.push_back(mk_point(-524288, -524288, -1));
    dir_q.push_back(mk_load(1, 524287, 524287, 524287, 0, 0, 32767));
    dir_q.push_back(mk_point(524287, 524287, -1));
    dir_q.push_back(mk_load(2, 100, 100, 1, 1, 32767, 0));
    dir_q.push_back(mk_load(0, 0, 0, 0, 0, 32767, 0));
    dir_q.push_back(mk_point(100, 100, -1));
    dir_q.push_back(mk_point(101, 100, -1));
    dir_q.push_back(mk_load(3, -1000, 2000, 4000, 800, 23170, 23170));
    dir_q.push_back(mk_load(4, 5000, -5000, 300, 9000, -32768, 32767));
    dir_q.push_back(mk_point(-1000, 2000, -1));
    dir_q.push_back(mk_point(5000, -5000, -1));
    dir_q.push_back(mk_point(-2400, 600, -1));
    dir_q.push_back(mk_point(524287, -524288, -1));
    foreach (dir_q[i]) send(dir_q[i]);

    // three random phases with different idling
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 16 : (ph == 1) ? 76 : 0;
      rx_idle = (ph == 0) ? 76 : (ph == 1) ? 16 : 0;
      for (int i = 0; i < 625; i++) begin
        if (ph == 2 && i == 20) hold_req = 1'b1;
        send(random_request());
      end
    end
    s_axis_tvalid <= 1'b0;

    while (region_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// File: ellipse_region_classifier.f
rtl/erc_pkg.sv
rtl/erc_serial_mul.sv
rtl/erc_tester.sv
rtl/ellipse_region_classifier.sv
verif/testbench.sv
